@@ sv/moment_accumulator_assert.svh @@
// Assertion macros for the moment accumulator checks.
`ifndef MOMENT_ACCUMULATOR_ASSERT_SVH
`define MOMENT_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define MA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("moment_accumulator: same-cycle check failed");

// next-cycle implication
`define MA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("moment_accumulator: next-cycle check failed");

`endif

@@ sv/ma_pkg.sv @@
// Types and constants shared by the moment accumulator modules.
package ma_pkg;
    localparam int NUM_CH    = 6;
    localparam int NUM_CROSS = NUM_CH * (NUM_CH - 1) / 2;
    localparam int NUM_MOM   = 2 * NUM_CH + NUM_CROSS;
    localparam int VAL_W     = 16;
    localparam int TICK_W    = 16;
    localparam int IDX_W     = 5;
    localparam int SUM_W     = 48;
    localparam int LIN_W     = 32;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int CNT_W     = 16;
    localparam int CH_W      = $clog2(NUM_CH);
    localparam int CR_W      = $clog2(NUM_CROSS);
    localparam int IN_W      = TICK_W + NUM_CH * VAL_W;
    localparam int OUT_USED  = IDX_W + SUM_W + CNT_W + 1;
    localparam int OUT_W     = ((OUT_USED + 7) / 8) * 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW   = $clog2(FIFO_DEPTH);

    localparam logic [CNT_W-1:0]  CNT_MAX         = {CNT_W{1'b1}};
    localparam logic [TICK_W-1:0] RECORD_TIME_RST = 16'd50;

    typedef enum logic {
        OP_SAMPLE  = 1'b0,
        OP_READOUT = 1'b1
    } t_op;

    typedef enum logic {
        REG_RECORD_TIME = 1'b0
    } t_reg;

    typedef logic [NUM_CH-1:0][VAL_W-1:0] t_vals;

    typedef struct packed {
        t_op   op;
        t_vals vals;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;
endpackage

@@ sv/moment_accumulator.sv @@
// Top level of the running first and second moment accumulator.
//
//  channel   direction  handshake                    contents
//  s_axis    in         s_axis_tvalid/tready         tick, six values, operation
//  m_axis    out        m_axis_tvalid/tready         index, sum, count, overflow, last
//  apb       in         psel/penable/pwrite/pready   record_time at address 0
//
// A sample item is taken from the queue every cycle while the queue holds one and no readout
// is busy; its products are registered in the product stage and then added into the sums.
// A readout item emits 27 result items, one per cycle while the output is
// taken, then clears all sums; the product stage drains first.
// A four-entry command queue lets input and output stall independently.
// Reset is synchronous: sums, count and flag clear, record_time becomes 50.
module moment_accumulator
    import ma_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // time_tick, value_0 .. value_5
    input  logic [0:0]       s_axis_tuser,   // operation
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // moment_index, moment_sum,
                                             // sample_count, overflow, zero pad
    output logic             m_axis_tlast,   // last
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    t_fifo_stat w_stat;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;
    t_cmd       w_head;

    ma_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_stat        (w_stat),
        .o_push        (w_push),
        .o_cmd         (w_cmd)
    );

    ma_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_cmd),
        .i_pop      (w_pop),
        .o_head     (w_head),
        .o_stat     (w_stat)
    );

    ma_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_stat        (w_stat),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );
endmodule

@@ sv/ma_fifo.sv @@
// Command queue between the front and back parts of the accumulator.
module ma_fifo
    import ma_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd       i_push_cmd,
    input  logic       i_pop,
    output t_cmd       o_head,
    output t_fifo_stat o_stat
);
    t_cmd               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + (FIFO_AW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - (FIFO_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_fill == (FIFO_AW + 1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_fill == '0);
endmodule

@@ sv/ma_front.sv @@
// Front part: register port, input acceptance and item classification.
module ma_front
    import ma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic [0:0]        s_axis_tuser,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  t_fifo_stat        i_stat,
    output logic              o_push,
    output t_cmd              o_cmd
);
    logic [TICK_W-1:0] r_record_time;
    logic [TICK_W-1:0] w_tick;
    t_op               w_op;
    t_reg              w_reg;

    assign w_reg = t_reg'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_record_time <= RECORD_TIME_RST;
        end else if (psel && penable && pwrite && (w_reg == REG_RECORD_TIME)) begin
            r_record_time <= pwdata[TICK_W-1:0];
        end
    end

    always_comb begin
        case (w_reg)
            REG_RECORD_TIME: prdata = 32'(r_record_time);
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign w_op   = t_op'(s_axis_tuser[0]);
    assign w_tick = s_axis_tdata[TICK_W-1:0];

    assign s_axis_tready = !i_stat.full;
    // sample items with mismatched ticks are dropped here and never reach the queue
    assign o_push     = s_axis_tvalid && s_axis_tready
                        && ((w_op == OP_READOUT) || (w_tick == r_record_time));
    assign o_cmd.op   = w_op;
    assign o_cmd.vals = s_axis_tdata[TICK_W +: NUM_CH*VAL_W];
endmodule

@@ sv/ma_back.sv @@
// Back part: product stage, moment sums and readout sequencing.
module ma_back
    import ma_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_head,
    input  t_fifo_stat       i_stat,
    output logic             o_pop,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,
    output logic             m_axis_tlast
);
    logic [LIN_W-1:0]  r_lin [NUM_CH];
    logic [SUM_W-1:0]  r_sq  [NUM_CH];
    logic [SUM_W-1:0]  r_cr  [NUM_CROSS];
    logic [CNT_W-1:0]  r_count;
    logic              r_drop;
    logic              r_busy;
    logic [IDX_W-1:0]  r_idx;

    logic              r_p_vld;
    t_vals             r_p_val;
    logic [PROD_W-1:0] r_p_sq [NUM_CH];
    logic [PROD_W-1:0] r_p_cr [NUM_CROSS];

    logic              r_out_vld;
    logic [IDX_W-1:0]  r_out_idx;
    logic [SUM_W-1:0]  r_out_sum;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_ovf;
    logic              r_out_last;

    logic              w_out_free;
    logic              w_take;
    logic              w_acc;
    logic              w_start;
    logic              w_emit;
    logic              w_end;
    logic [IDX_W-1:0]  w_off_sq;
    logic [IDX_W-1:0]  w_off_cr;
    logic [SUM_W-1:0]  w_sel;

    assign w_out_free = !r_out_vld || m_axis_tready;
    // a readout waits for the product stage to drain into the sums
    assign o_pop   = !i_stat.empty && !r_busy
                     && ((i_head.op == OP_SAMPLE) || !r_p_vld);
    assign w_take  = o_pop && (i_head.op == OP_SAMPLE);
    assign w_acc   = w_take && (r_count != CNT_MAX);
    assign w_start = o_pop && (i_head.op == OP_READOUT);
    assign w_emit  = r_busy && w_out_free;
    assign w_end   = w_emit && (r_idx == IDX_W'(NUM_MOM - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_end) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (w_acc) begin
            r_count <= r_count + CNT_W'(1);
        end else if (w_take) begin
            r_drop  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_start) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_end) begin
            r_busy <= 1'b0;
        end else if (w_emit) begin
            r_idx  <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_p_val <= i_head.vals;
        end
    end

    for (genvar i = 0; i < NUM_CH; i++) begin : g_ch
        always_ff @(posedge i_clk) begin
            if (w_acc) begin
                r_p_sq[i] <= PROD_W'(i_head.vals[i]) * PROD_W'(i_head.vals[i]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || w_end) begin
                r_lin[i] <= '0;
                r_sq[i]  <= '0;
            end else if (r_p_vld) begin
                r_lin[i] <= r_lin[i] + LIN_W'(r_p_val[i]);
                r_sq[i]  <= r_sq[i] + SUM_W'(r_p_sq[i]);
            end
        end

        for (genvar j = i + 1; j < NUM_CH; j++) begin : g_pair
            localparam int K = i * (2 * NUM_CH - i - 1) / 2 + (j - i - 1);

            always_ff @(posedge i_clk) begin
                if (w_acc) begin
                    r_p_cr[K] <= PROD_W'(i_head.vals[i]) * PROD_W'(i_head.vals[j]);
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n || w_end) begin
                    r_cr[K] <= '0;
                end else if (r_p_vld) begin
                    r_cr[K] <= r_cr[K] + SUM_W'(r_p_cr[K]);
                end
            end
        end
    end

    assign w_off_sq = r_idx - IDX_W'(NUM_CH);
    assign w_off_cr = r_idx - IDX_W'(2 * NUM_CH);

    always_comb begin
        if (r_idx < IDX_W'(NUM_CH)) begin
            w_sel = SUM_W'(r_lin[r_idx[CH_W-1:0]]);
        end else if (r_idx < IDX_W'(2 * NUM_CH)) begin
            w_sel = r_sq[w_off_sq[CH_W-1:0]];
        end else begin
            w_sel = r_cr[w_off_cr[CR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_idx  <= r_idx;
            r_out_sum  <= w_sel;
            r_out_cnt  <= r_count;
            r_out_ovf  <= r_drop;
            r_out_last <= (r_idx == IDX_W'(NUM_MOM - 1));
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {(OUT_W - OUT_USED)'(0), r_out_ovf, r_out_cnt, r_out_sum, r_out_idx};
    assign m_axis_tlast  = r_out_last;
endmodule

@@ sv/ma_checker.sv @@
// Port-level checks for the moment accumulator and their bind.
`include "moment_accumulator_assert.svh"

module ma_checker
    import ma_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast
);
    localparam int CNT_LSB = IDX_W + SUM_W;
    localparam int OVF_BIT = CNT_LSB + CNT_W;

    logic [IDX_W-1:0] w_idx;
    logic [CNT_W-1:0] w_cnt;
    logic             w_ovf;

    assign w_idx = m_axis_tdata[IDX_W-1:0];
    assign w_cnt = m_axis_tdata[CNT_LSB +: CNT_W];
    assign w_ovf = m_axis_tdata[OVF_BIT];

    `MA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    `MA_ASSERT_NOW(a_last_at_end, i_clk, i_rst_n, m_axis_tvalid, m_axis_tlast == (w_idx == IDX_W'(NUM_MOM - 1)))
    `MA_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, m_axis_tvalid, w_idx <= IDX_W'(NUM_MOM - 1))
    `MA_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, m_axis_tvalid && w_ovf, w_cnt == CNT_MAX)
endmodule

bind moment_accumulator ma_checker u_ma_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

@@ tb/moment_accumulator_tb.sv @@
// Self-checking stream testbench for the moment accumulator with its own moment predictor.
module moment_accumulator_tb;
    import ma_pkg::*;

    localparam int SUM_LSB = IDX_W;
    localparam int CNT_LSB = IDX_W + SUM_W;
    localparam int OVF_BIT = IDX_W + SUM_W + CNT_W;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 400;
    localparam logic [2:0] ADDR_RECORD_TIME = 3'(4 * REG_RECORD_TIME);
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef struct packed {
        t_op               op;
        logic [TICK_W-1:0] tick;
        t_vals             vals;
    } t_sample_item;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic             ovf;
        logic             last;
    } t_moment;

    logic             i_clk;
    logic             i_rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata = '0;
    logic [0:0]       s_axis_tuser = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             m_axis_tlast;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [2:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    moment_accumulator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    t_sample_item pending_q [$];
    t_moment      moment_q [$];
    int           mismatch_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           hold_req = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    // predictor state
    logic [TICK_W-1:0] record_time_q = RECORD_TIME_RST;
    logic [LIN_W-1:0]  lin_sum [NUM_CH] = '{default: '0};
    logic [SUM_W-1:0]  sq_sum [NUM_CH] = '{default: '0};
    logic [SUM_W-1:0]  cross_sum [NUM_CROSS] = '{default: '0};
    logic [CNT_W-1:0]  n_samples = '0;
    logic              dropped = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic accumulate_moments(input t_sample_item it);
        t_moment r;
        int      k;
        if (it.op == OP_READOUT) begin
            for (int m = 0; m < NUM_MOM; m++) begin
                r.idx = IDX_W'(m);
                if (m < NUM_CH) r.sum = SUM_W'(lin_sum[m]);
                else if (m < 2 * NUM_CH) r.sum = sq_sum[m - NUM_CH];
                else r.sum = cross_sum[m - 2 * NUM_CH];
                r.cnt  = n_samples;
                r.ovf  = dropped;
                r.last = (m == NUM_MOM - 1);
                moment_q.insert(moment_q.size(), r);
            end
            lin_sum   = '{default: '0};
            sq_sum    = '{default: '0};
            cross_sum = '{default: '0};
            n_samples = '0;
            dropped   = 1'b0;
        end else if (it.tick == record_time_q) begin
            if (n_samples == CNT_MAX) begin
                dropped = 1'b1;
            end else begin
                k = 0;
                for (int i = 0; i < NUM_CH; i++) begin
                    lin_sum[i] = lin_sum[i] + LIN_W'(it.vals[i]);
                    sq_sum[i]  = sq_sum[i] + SUM_W'(it.vals[i]) * SUM_W'(it.vals[i]);
                    for (int j = i + 1; j < NUM_CH; j++) begin
                        cross_sum[k] = cross_sum[k] + SUM_W'(it.vals[i]) * SUM_W'(it.vals[j]);
                        k++;
                    end
                end
                n_samples = n_samples + 1'b1;
            end
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        t_sample_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.vals, nxt.tick};
                s_axis_tuser  <= nxt.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on accepted input, check accepted output
    always @(posedge i_clk) begin
        t_sample_item acc;
        t_moment      want;
        t_moment      got;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                acc.op   = t_op'(s_axis_tuser[0]);
                acc.tick = s_axis_tdata[TICK_W-1:0];
                acc.vals = s_axis_tdata[IN_W-1:TICK_W];
                accumulate_moments(acc);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.idx  = m_axis_tdata[IDX_W-1:0];
                got.sum  = m_axis_tdata[SUM_LSB +: SUM_W];
                got.cnt  = m_axis_tdata[CNT_LSB +: CNT_W];
                got.ovf  = m_axis_tdata[OVF_BIT];
                got.last = m_axis_tlast;
                if (moment_q.size() == 0) begin
                    $display("%0t: unexpected result idx %0d sum %0h", $time, got.idx, got.sum);
                    mismatch_count++;
                end else begin
                    want = moment_q.pop_front();
                    if (got.idx !== want.idx) begin
                        $display("%0t: moment_index expected %0d actual %0d",
                                 $time, want.idx, got.idx);
                        mismatch_count++;
                    end
                    if (got.sum !== want.sum) begin
                        $display("%0t: moment_sum[%0d] expected %0h actual %0h",
                                 $time, want.idx, want.sum, got.sum);
                        mismatch_count++;
                    end
                    if (got.cnt !== want.cnt) begin
                        $display("%0t: sample_count expected %0d actual %0d",
                                 $time, want.cnt, got.cnt);
                        mismatch_count++;
                    end
                    if (got.ovf !== want.ovf) begin
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, want.ovf, got.ovf);
                        mismatch_count++;
                    end
                    if (got.last !== want.last) begin
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, got.last);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return VAL_W'($urandom_range(255));
            1: return ($urandom_range(1) != 0) ? {VAL_W{1'b1}} : {VAL_W{1'b0}};
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic t_vals rand_vals();
        t_vals v;
        for (int c = 0; c < NUM_CH; c++) v[c] = rand_value();
        return v;
    endfunction

    task automatic push_item(input t_op op, input logic [TICK_W-1:0] tick, input t_vals v);
        t_sample_item it;
        it.op   = op;
        it.tick = tick;
        it.vals = v;
        pending_q.insert(pending_q.size(), it);
    endtask

    task automatic push_readout();
        push_item(OP_READOUT, TICK_W'($urandom), rand_vals());
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || s_axis_tvalid || moment_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_RECORD_TIME) record_time_q = data[TICK_W-1:0];
    endtask

    task automatic run_random(input int n, input int idle_pct, input int stall_pct,
                              input logic [TICK_W-1:0] rec, input int readout_pct);
        int r;
        wait_idle();
        write_reg(ADDR_RECORD_TIME, 32'(rec));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < readout_pct) push_readout();
            else if (r < 72) push_item(OP_SAMPLE, record_time_q, rand_vals());
            else if (r < 86) push_item(OP_SAMPLE, record_time_q + (r[0] ? 16'd1 : -16'd1),
                                       rand_vals());
            else push_item(OP_SAMPLE, TICK_W'($urandom), rand_vals());
        end
        push_readout();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset record time
        push_readout();
        push_item(OP_SAMPLE, 16'd50, {NUM_CH{16'hFFFF}});
        push_item(OP_SAMPLE, 16'd50, {NUM_CH{16'h0000}});
        push_item(OP_SAMPLE, 16'd49, {NUM_CH{16'h1111}});
        push_item(OP_SAMPLE, 16'd51, {NUM_CH{16'h2222}});
        push_item(OP_SAMPLE, 16'd50,
                  {16'hA5A5, 16'h0040, 16'hFFFF, 16'h1234, 16'h8000, 16'h0001});
        push_readout();
        push_readout();

        // write to an unmapped address leaves record time alone
        wait_idle();
        write_reg(ADDR_UNUSED, 32'd7);
        push_item(OP_SAMPLE, 16'd50, {NUM_CH{16'h0101}});
        push_item(OP_SAMPLE, 16'd7, {NUM_CH{16'h2222}});
        push_readout();

        wait_idle();
        write_reg(ADDR_RECORD_TIME, 32'h0000_0000);
        push_item(OP_SAMPLE, 16'h0000, {NUM_CH{16'h7FFF}});
        push_item(OP_SAMPLE, 16'hFFFF, {NUM_CH{16'h3333}});
        push_readout();

        wait_idle();
        write_reg(ADDR_RECORD_TIME, 32'h0000_FFFF);
        push_item(OP_SAMPLE, 16'hFFFF, {NUM_CH{16'hC000}});
        push_item(OP_SAMPLE, 16'h0000, {NUM_CH{16'h4444}});
        push_readout();

        run_random(92, 0, 0, TICK_W'($urandom), 12);
        run_random(92, 80, 0, 16'h0000, 12);
        run_random(92, 0, 80, 16'hFFFF, 12);
        run_random(92, 13, 13, 16'd50, 12);

        // receiver holds off while the sender keeps offering
        run_random(40, 0, 0, TICK_W'($urandom), 35);
        hold_req++;

        wait_idle();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
